### hw/rtl/trs_pkg.sv
// Package for the TRS model matrix builder: types, constants, CORDIC table.
`default_nettype none
package trs_pkg;

  localparam int CordicSteps = 16;
  localparam int AtanEntries = 24;
  localparam int NumSteps = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;
  localparam int StepW = $clog2(NumSteps + 1);
  localparam int QDepth = 2;

  localparam logic signed [33:0] CordicStartX = 34'sd652032874;
  localparam logic signed [15:0] Deg360 = 16'sd23040;
  localparam logic signed [15:0] Deg180 = 16'sd11520;
  localparam logic signed [15:0] Deg90 = 16'sd5760;
  localparam logic signed [31:0] OneQ16 = 32'sd65536;

  // Front/back handoff after classification
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] scl;
    logic [2:0][15:0] ang;
    logic [2:0]       neg;
    logic             fin;
  } trs_job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_CORDIC, BK_PROD1, BK_PROD2, BK_ROWS
  } trs_bk_state_t;

  function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
    logic signed [31:0] v;
    begin
      case (i)
        5'd0: v = 32'sd188743680;  5'd1: v = 32'sd111421900;
        5'd2: v = 32'sd58872272;   5'd3: v = 32'sd29884485;
        5'd4: v = 32'sd15000234;   5'd5: v = 32'sd7507429;
        5'd6: v = 32'sd3754631;    5'd7: v = 32'sd1877430;
        5'd8: v = 32'sd938729;     5'd9: v = 32'sd469366;
        5'd10: v = 32'sd234683;    5'd11: v = 32'sd117342;
        5'd12: v = 32'sd58671;     5'd13: v = 32'sd29335;
        5'd14: v = 32'sd14668;     5'd15: v = 32'sd7334;
        5'd16: v = 32'sd3667;      5'd17: v = 32'sd1833;
        5'd18: v = 32'sd917;       5'd19: v = 32'sd458;
        5'd20: v = 32'sd229;       5'd21: v = 32'sd115;
        5'd22: v = 32'sd57;        5'd23: v = 32'sd29;
        default: v = 32'sd0;
      endcase
      return v;
    end
  endfunction

  // Q4.30 product, round half up
  function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
    logic signed [67:0] p;
    begin
      p = a * b + (68'sd1 <<< 29);
      return 34'(p >>> 30);
    end
  endfunction

  // Rotation element times Q16.16 scale, rounded and saturated
  function automatic logic [31:0] scale_elem(input logic signed [33:0] r,
                                             input logic signed [31:0] s);
    logic signed [66:0] p;
    logic signed [36:0] v;
    begin
      p = 67'(r) * 67'(s) + (67'sd1 <<< 29);
      v = 37'(p >>> 30);
      if (v > 37'sd2147483647) return 32'h7fffffff;
      if (v < -37'sd2147483648) return 32'h80000000;
      return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/trs_ifc.sv
// Valid/ready channel interfaces for entity requests and row results.
`default_nettype none
interface trs_in_if (input wire logic clk);
  logic valid;
  logic ready;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [15:0] angle_x, angle_y, angle_z;
  logic signed [31:0] scale_x, scale_y, scale_z;
  logic final_entity;
  modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                  scale_x, scale_y, scale_z, final_entity, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                scale_x, scale_y, scale_z, final_entity, output ready);
endinterface

interface trs_out_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [1:0] row_index;
  logic signed [31:0] elem_c0, elem_c1, elem_c2, elem_c3;
  logic last_row;
  logic end_of_batch;
  modport source (output valid, row_index, elem_c0, elem_c1, elem_c2, elem_c3,
                  last_row, end_of_batch, input ready);
  modport sink (input valid, row_index, elem_c0, elem_c1, elem_c2, elem_c3,
                last_row, end_of_batch, output ready);
endinterface
`default_nettype wire

### hw/rtl/trs_front.sv
// Front end: takes entity requests, folds angles into +-90 degrees, queues jobs.
`default_nettype none
module trs_front (
  input  wire logic     clk,
  input  wire logic     rst_n,
  trs_in_if.sink        in_ch,
  output trs_pkg::trs_job_t job,
  output logic          job_valid,
  input  wire logic     job_take
);
  localparam int PtrW = $clog2(trs_pkg::QDepth);

  trs_pkg::trs_job_t q_r [trs_pkg::QDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;
  trs_pkg::trs_job_t cls;
  logic push, pop;

  // Fold one angle: wrap modulo 360, then into [-90, 90] with sign flag
  function automatic logic [16:0] fold(input logic signed [15:0] a);
    logic signed [16:0] w;
    logic n;
    begin
      w = 17'(a);
      if (w > 17'(trs_pkg::Deg180)) w = w - 17'(trs_pkg::Deg360);
      else if (w <= -17'(trs_pkg::Deg180)) w = w + 17'(trs_pkg::Deg360);
      if (w > 17'(trs_pkg::Deg180)) w = w - 17'(trs_pkg::Deg360);
      else if (w <= -17'(trs_pkg::Deg180)) w = w + 17'(trs_pkg::Deg360);
      n = 1'b0;
      if (w > 17'(trs_pkg::Deg90)) begin
        w = w - 17'(trs_pkg::Deg180); n = 1'b1;
      end else if (w < -17'(trs_pkg::Deg90)) begin
        w = w + 17'(trs_pkg::Deg180); n = 1'b1;
      end
      return {n, w[15:0]};
    end
  endfunction

  // Classify the incoming request
  always_comb begin
    logic [16:0] fx, fy, fz;
    fx = fold(in_ch.angle_x);
    fy = fold(in_ch.angle_y);
    fz = fold(in_ch.angle_z);
    cls.pos = {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
    cls.scl = {in_ch.scale_z, in_ch.scale_y, in_ch.scale_x};
    cls.ang = {fz[15:0], fy[15:0], fx[15:0]};
    cls.neg = {fz[16], fy[16], fx[16]};
    cls.fin = in_ch.final_entity;
  end

  assign in_ch.ready = (cnt_r != (PtrW+1)'(trs_pkg::QDepth));
  assign push = in_ch.valid && in_ch.ready;
  assign job_valid = (cnt_r != '0);
  assign pop = job_valid && job_take;
  assign job = q_r[rp_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PtrW+1)'(trs_pkg::QDepth)) else $error("queue overfull");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !pop) else $error("pop from empty queue");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (PtrW+1)'(trs_pkg::QDepth)) |-> !push) else $error("push into full queue");
endmodule
`default_nettype wire

### hw/rtl/trs_back.sv
// Back end: three parallel CORDIC lanes, product stages and row emission.
`default_nettype none
module trs_back (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire trs_pkg::trs_job_t job,
  input  wire logic     job_valid,
  output logic          job_take,
  trs_out_if.source     out_ch
);
  trs_pkg::trs_bk_state_t st_r, st_nxt;
  logic [trs_pkg::StepW-1:0] step_r;
  logic signed [33:0] x_r [3], y_r [3];
  logic signed [31:0] z_r [3];
  trs_pkg::trs_job_t jb_r;
  logic signed [33:0] s_x, c_x, s_y, c_y, s_z, c_z;
  logic signed [33:0] t_r, u_r, p00_r, p01_r, p02_r, p12_r, p22_r;
  logic signed [33:0] cxsz_r, cxcz_r, sxsz_r, sxcz_r;
  logic signed [33:0] m_r [3][3];
  logic [1:0] row_r;
  logic ov_r;
  logic last_step;
  logic ld_out;

  assign last_step = (step_r == trs_pkg::StepW'(trs_pkg::NumSteps - 1));

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      trs_pkg::BK_IDLE:   if (job_valid) st_nxt = trs_pkg::BK_CORDIC;
      trs_pkg::BK_CORDIC: if (last_step) st_nxt = trs_pkg::BK_PROD1;
      trs_pkg::BK_PROD1:  st_nxt = trs_pkg::BK_PROD2;
      trs_pkg::BK_PROD2:  st_nxt = trs_pkg::BK_ROWS;
      trs_pkg::BK_ROWS:
        if (ld_out && row_r == 2'd3) st_nxt = trs_pkg::BK_IDLE;
      default: st_nxt = trs_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    job_take = 1'b0;
    ld_out = 1'b0;
    case (st_r)
      trs_pkg::BK_IDLE: job_take = job_valid;
      trs_pkg::BK_ROWS: ld_out = !ov_r || out_ch.ready;
      default: ;
    endcase
  end

  // Signs applied after CORDIC
  assign c_x = jb_r.neg[0] ? -x_r[0] : x_r[0];
  assign s_x = jb_r.neg[0] ? -y_r[0] : y_r[0];
  assign c_y = jb_r.neg[1] ? -x_r[1] : x_r[1];
  assign s_y = jb_r.neg[1] ? -y_r[1] : y_r[1];
  assign c_z = jb_r.neg[2] ? -x_r[2] : x_r[2];
  assign s_z = jb_r.neg[2] ? -y_r[2] : y_r[2];

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= trs_pkg::BK_IDLE;
      step_r <= '0;
      row_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (job_take) step_r <= '0;
      else if (st_r == trs_pkg::BK_CORDIC) step_r <= step_r + 1'b1;
      if (job_take) row_r <= '0;
      else if (ld_out) row_r <= row_r + 1'b1;
      if (ld_out) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  // CORDIC lanes, one step per cycle
  always_ff @(posedge clk) begin
    if (job_take) begin
      jb_r <= job;
      for (int k = 0; k < 3; k++) begin
        x_r[k] <= trs_pkg::CordicStartX;
        y_r[k] <= '0;
        z_r[k] <= 32'(signed'(job.ang[k])) * 32'sd65536;
      end
    end else if (st_r == trs_pkg::BK_CORDIC) begin
      for (int k = 0; k < 3; k++) begin
        if (!z_r[k][31]) begin
          x_r[k] <= x_r[k] - (y_r[k] >>> step_r);
          y_r[k] <= y_r[k] + (x_r[k] >>> step_r);
          z_r[k] <= z_r[k] - trs_pkg::atan_lut(5'(step_r));
        end else begin
          x_r[k] <= x_r[k] + (y_r[k] >>> step_r);
          y_r[k] <= y_r[k] - (x_r[k] >>> step_r);
          z_r[k] <= z_r[k] + trs_pkg::atan_lut(5'(step_r));
        end
      end
    end
  end

  // Products: first level, then three-factor terms
  always_ff @(posedge clk) begin
    if (st_r == trs_pkg::BK_PROD1) begin
      t_r <= trs_pkg::mul30(s_x, s_y);
      u_r <= trs_pkg::mul30(c_x, s_y);
      p00_r <= trs_pkg::mul30(c_y, c_z);
      p01_r <= -trs_pkg::mul30(c_y, s_z);
      p02_r <= s_y;
      p12_r <= -trs_pkg::mul30(s_x, c_y);
      p22_r <= trs_pkg::mul30(c_x, c_y);
      cxsz_r <= trs_pkg::mul30(c_x, s_z);
      cxcz_r <= trs_pkg::mul30(c_x, c_z);
      sxsz_r <= trs_pkg::mul30(s_x, s_z);
      sxcz_r <= trs_pkg::mul30(s_x, c_z);
    end
    if (st_r == trs_pkg::BK_PROD2) begin
      m_r[0][0] <= p00_r;
      m_r[0][1] <= p01_r;
      m_r[0][2] <= p02_r;
      m_r[1][0] <= trs_pkg::mul30(t_r, c_z) + cxsz_r;
      m_r[1][1] <= cxcz_r - trs_pkg::mul30(t_r, s_z);
      m_r[1][2] <= p12_r;
      m_r[2][0] <= sxsz_r - trs_pkg::mul30(u_r, c_z);
      m_r[2][1] <= trs_pkg::mul30(u_r, s_z) + sxcz_r;
      m_r[2][2] <= p22_r;
    end
  end

  // Output register: one row per load, four rows per entity
  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_ch.row_index <= row_r;
      out_ch.last_row <= (row_r == 2'd3);
      out_ch.end_of_batch <= (row_r == 2'd3) && jb_r.fin;
      if (row_r == 2'd3) begin
        out_ch.elem_c0 <= '0;
        out_ch.elem_c1 <= '0;
        out_ch.elem_c2 <= '0;
        out_ch.elem_c3 <= trs_pkg::OneQ16;
      end else begin
        out_ch.elem_c0 <= trs_pkg::scale_elem(m_r[row_r][0], jb_r.scl[0]);
        out_ch.elem_c1 <= trs_pkg::scale_elem(m_r[row_r][1], jb_r.scl[1]);
        out_ch.elem_c2 <= trs_pkg::scale_elem(m_r[row_r][2], jb_r.scl[2]);
        out_ch.elem_c3 <= jb_r.pos[row_r];
      end
    end
  end
  assign out_ch.valid = ov_r;

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> (st_r == trs_pkg::BK_IDLE)) else $error("job taken while busy");
  a_last_eob: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_ch.end_of_batch) |-> out_ch.last_row) else $error("eob off last row");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> ov_r) else $error("result dropped");
endmodule
`default_nettype wire

### hw/rtl/trs_model_matrix_builder_core.sv
// Top level of the TRS model matrix builder.
// A request flows through the front queue, CORDIC lanes, product stages and output
// register; rows then leave one per cycle while out_ch.ready holds. The back end takes
// a new entity only after loading the last row of the one before; the front queue takes
// two requests ahead. Synchronous active-low reset clears queue and sequencer state.
`default_nettype none
module trs_model_matrix_builder_core (
  input  wire logic clk,
  input  wire logic rst_n,
  trs_in_if.sink    in_ch,
  trs_out_if.source out_ch
);
  trs_pkg::trs_job_t job;
  logic job_valid, job_take;

  trs_front u_front (.clk, .rst_n, .in_ch, .job, .job_valid, .job_take);
  trs_back  u_back  (.clk, .rst_n, .job, .job_valid, .job_take, .out_ch);
endmodule
`default_nettype wire
